FILE: rtl/core/ntr_pkg.sv
// shared types and constants for the neighbor mask autotile resolver
// used by the front, engine and top modules under rtl/core, no dependencies
package ntr_pkg;

  localparam int TILE_W         = 16;
  localparam int VARIANTS       = 16;
  localparam int VAR_W          = 4;
  localparam int NB_COUNT       = 4;
  localparam int RULE_SLOTS_DEF = 8;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_CLEAR   = 2'd1;
  localparam logic [1:0] CMD_RESOLVE = 2'd2;

  typedef logic signed [TILE_W-1:0] tile_t;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_CLEAR,
    OP_RESOLVE,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [1:0]          cmd;
    tile_t               base_id;
    logic [VAR_W-1:0]    variant_index;
    tile_t               variant_value;
    tile_t               center_tile;
    tile_t               up_tile;
    tile_t               right_tile;
    tile_t               down_tile;
    tile_t               left_tile;
    logic [NB_COUNT-1:0] neighbor_present;
  } in_item_t;

  typedef struct packed {
    tile_t new_tile;
    logic  rule_applied;
    logic  table_full;
  } out_item_t;

  typedef struct packed {
    op_t      op;
    tile_t    key;
    in_item_t item;
  } work_t;

endpackage

FILE: rtl/core/ntr_fifo.sv
// small register fifo used between the front, engine and result side
// generic width, no package dependencies
module ntr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr + 1'b1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr + 1'b1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= CNTW'(count + 1'b1);
        2'b01:   count <= CNTW'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

FILE: rtl/core/ntr_front.sv
// front end: takes input transactions, decodes the command and lookup key
// depends on ntr_pkg and ntr_fifo
module ntr_front (
  input  logic             clk,
  input  logic             rst,
  input  ntr_pkg::in_item_t item,
  input  logic             push,
  output logic             full,
  output ntr_pkg::work_t   wk,
  output logic             wk_empty,
  input  logic             wk_pop
);

  ntr_pkg::work_t   dec;
  logic [$bits(ntr_pkg::work_t)-1:0] wk_bits;

  always_comb begin
    dec.item = item;
    unique case (item.cmd)
      ntr_pkg::CMD_WRITE:   dec.op = ntr_pkg::OP_WRITE;
      ntr_pkg::CMD_CLEAR:   dec.op = ntr_pkg::OP_CLEAR;
      ntr_pkg::CMD_RESOLVE: dec.op = ntr_pkg::OP_RESOLVE;
      default:              dec.op = ntr_pkg::OP_NOP;
    endcase
    dec.key = (dec.op == ntr_pkg::OP_RESOLVE) ? item.center_tile : item.base_id;
  end

  ntr_fifo #(
    .WIDTH($bits(ntr_pkg::work_t)),
    .DEPTH(ntr_pkg::QUEUE_DEPTH)
  ) u_work_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (dec),
    .full    (full),
    .rd_en   (wk_pop),
    .rd_data (wk_bits),
    .empty   (wk_empty)
  );

  assign wk = wk_bits;

endmodule

FILE: rtl/core/ntr_engine.sv
// back end: rule table storage and the scan sequencer for write, clear, resolve
// depends on ntr_pkg
module ntr_engine #(
  parameter int RULE_SLOTS = ntr_pkg::RULE_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ntr_pkg::work_t     wk,
  input  logic               wk_empty,
  output logic               wk_pop,
  output ntr_pkg::out_item_t res,
  output logic               res_push,
  input  logic               res_full
);

  localparam int SW    = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int CW    = $clog2(RULE_SLOTS + 1);
  localparam int VW    = ntr_pkg::VAR_W;
  localparam int AW    = SW + VW;
  localparam int NB    = ntr_pkg::NB_COUNT;
  localparam int TW    = ntr_pkg::TILE_W;
  localparam int DEPTH = RULE_SLOTS * ntr_pkg::VARIANTS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BSCAN,
    S_FILL,
    S_VSCAN,
    S_BREAD,
    S_BWAIT,
    S_NSCAN,
    S_VREAD,
    S_VWAIT,
    S_DONE
  } state_t;

  // rule table
  logic [TW-1:0]         base_mem [RULE_SLOTS];
  logic [TW-1:0]         var_mem  [DEPTH];
  logic [RULE_SLOTS-1:0] active;
  logic [CW-1:0]         rule_count, rule_count_next;
  logic [TW-1:0]         base_rdata;
  logic [TW-1:0]         var_rdata;

  // sequencer registers
  state_t                state, state_next;
  ntr_pkg::op_t          op, op_next;
  ntr_pkg::tile_t        key, key_next;
  ntr_pkg::in_item_t     itm, itm_next;
  logic [CW-1:0]         scan_slot, scan_slot_next;
  logic [VW:0]           scan_v, scan_v_next;
  logic                  rd_vld, rd_vld_next;
  logic [SW-1:0]         rd_slot, rd_slot_next;
  logic [SW-1:0]         slot, slot_next;
  logic [TW-1:0]         fam_base, fam_base_next;
  logic [NB-1:0]         hits, hits_next;
  ntr_pkg::out_item_t    res_next;

  // memory and mark controls
  logic                  base_we;
  logic [SW-1:0]         base_waddr;
  logic [SW-1:0]         base_raddr;
  logic                  var_we;
  logic [AW-1:0]         var_waddr;
  logic [TW-1:0]         var_wdata;
  logic [AW-1:0]         var_raddr;
  logic                  act_we;
  logic [SW-1:0]         act_idx;
  logic                  act_val;

  logic [TW-1:0]         nb [NB];
  logic [NB-1:0]         base_hits;
  logic [VW-1:0]         mask;
  logic                  issue;
  logic                  slot_ok;

  always_comb begin
    nb[0] = itm.up_tile;
    nb[1] = itm.right_tile;
    nb[2] = itm.down_tile;
    nb[3] = itm.left_tile;
    for (int i = 0; i < NB; i++) begin
      base_hits[i] = (nb[i] == fam_base);
    end
    mask = (hits | base_hits) & itm.neighbor_present;
  end

  always_comb begin
    state_next      = state;
    op_next         = op;
    key_next        = key;
    itm_next        = itm;
    scan_slot_next  = scan_slot;
    scan_v_next     = scan_v;
    rd_vld_next     = 1'b0;
    rd_slot_next    = rd_slot;
    slot_next       = slot;
    fam_base_next   = fam_base;
    hits_next       = hits;
    res_next        = res;
    rule_count_next = rule_count;
    base_we         = 1'b0;
    base_waddr      = rule_count[SW-1:0];
    base_raddr      = scan_slot[SW-1:0];
    var_we          = 1'b0;
    var_waddr       = {slot, scan_v[VW-1:0]};
    var_wdata       = '0;
    var_raddr       = {scan_slot[SW-1:0], scan_v[VW-1:0]};
    act_we          = 1'b0;
    act_idx         = rd_slot;
    act_val         = 1'b0;
    wk_pop          = 1'b0;
    res_push        = 1'b0;
    issue           = 1'b0;
    slot_ok         = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (!wk_empty) begin
          wk_pop         = 1'b1;
          op_next        = wk.op;
          key_next       = wk.key;
          itm_next       = wk.item;
          scan_slot_next = '0;
          scan_v_next    = '0;
          hits_next      = '0;
          res_next       = '0;
          state_next     = (wk.op == ntr_pkg::OP_NOP) ? S_DONE : S_BSCAN;
        end
      end

      S_BSCAN: begin
        issue        = (scan_slot < rule_count);
        rd_vld_next  = issue;
        rd_slot_next = scan_slot[SW-1:0];
        if (issue) begin
          scan_slot_next = CW'(scan_slot + 1'b1);
        end
        if (rd_vld && (base_rdata == key) &&
            ((op != ntr_pkg::OP_RESOLVE) || active[rd_slot])) begin
          rd_vld_next   = 1'b0;
          slot_next     = rd_slot;
          fam_base_next = base_rdata;
          case (op)
            ntr_pkg::OP_WRITE: begin
              var_we     = 1'b1;
              var_waddr  = {rd_slot, itm.variant_index};
              var_wdata  = itm.variant_value;
              act_we     = 1'b1;
              act_val    = 1'b1;
              state_next = S_DONE;
            end
            ntr_pkg::OP_CLEAR: begin
              act_we     = 1'b1;
              state_next = S_DONE;
            end
            default: begin
              scan_v_next = '0;
              hits_next   = '0;
              state_next  = S_NSCAN;
            end
          endcase
        end else if (!issue && !rd_vld) begin
          case (op)
            ntr_pkg::OP_WRITE: begin
              if (rule_count == CW'(RULE_SLOTS)) begin
                res_next.table_full = 1'b1;
                state_next          = S_DONE;
              end else begin
                base_we         = 1'b1;
                slot_next       = rule_count[SW-1:0];
                rule_count_next = CW'(rule_count + 1'b1);
                act_we          = 1'b1;
                act_idx         = rule_count[SW-1:0];
                act_val         = 1'b1;
                scan_v_next     = '0;
                state_next      = S_FILL;
              end
            end
            ntr_pkg::OP_CLEAR: begin
              state_next = S_DONE;
            end
            default: begin
              scan_slot_next = '0;
              scan_v_next    = '0;
              state_next     = S_VSCAN;
            end
          endcase
        end
      end

      // new rule: zero every variant, the written one gets its value
      S_FILL: begin
        var_we      = 1'b1;
        var_wdata   = (scan_v[VW-1:0] == itm.variant_index) ? itm.variant_value : '0;
        scan_v_next = (VW+1)'(scan_v + 1'b1);
        if (scan_v[VW-1:0] == '1) begin
          state_next = S_DONE;
        end
      end

      // lowest active rule whose variants hold the center tile
      S_VSCAN: begin
        slot_ok      = (scan_slot < rule_count);
        issue        = slot_ok && active[scan_slot[SW-1:0]];
        rd_vld_next  = issue;
        rd_slot_next = scan_slot[SW-1:0];
        if (slot_ok && (!issue || (scan_v[VW-1:0] == '1))) begin
          scan_slot_next = CW'(scan_slot + 1'b1);
          scan_v_next    = '0;
        end else if (issue) begin
          scan_v_next = (VW+1)'(scan_v + 1'b1);
        end
        if (rd_vld && (var_rdata == key)) begin
          rd_vld_next = 1'b0;
          slot_next   = rd_slot;
          state_next  = S_BREAD;
        end else if (!slot_ok && !rd_vld) begin
          res_next.new_tile = key;
          state_next        = S_DONE;
        end
      end

      S_BREAD: begin
        base_raddr = slot;
        state_next = S_BWAIT;
      end

      S_BWAIT: begin
        fam_base_next = base_rdata;
        scan_v_next   = '0;
        hits_next     = '0;
        state_next    = S_NSCAN;
      end

      // neighbor family check against every variant of the chosen rule
      S_NSCAN: begin
        issue     = !scan_v[VW];
        var_raddr = {slot, scan_v[VW-1:0]};
        rd_vld_next = issue;
        if (issue) begin
          scan_v_next = (VW+1)'(scan_v + 1'b1);
        end
        if (rd_vld) begin
          for (int i = 0; i < NB; i++) begin
            hits_next[i] = hits[i] | (nb[i] == var_rdata);
          end
        end
        if (!issue && !rd_vld) begin
          state_next = S_VREAD;
        end
      end

      S_VREAD: begin
        var_raddr  = {slot, mask};
        state_next = S_VWAIT;
      end

      S_VWAIT: begin
        res_next.new_tile     = var_rdata;
        res_next.rule_applied = 1'b1;
        state_next            = S_DONE;
      end

      S_DONE: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rule_count <= '0;
      active     <= '0;
      rd_vld     <= 1'b0;
    end else begin
      state      <= state_next;
      rule_count <= rule_count_next;
      rd_vld     <= rd_vld_next;
      if (act_we) begin
        active[act_idx] <= act_val;
      end
    end
    op        <= op_next;
    key       <= key_next;
    itm       <= itm_next;
    scan_slot <= scan_slot_next;
    scan_v    <= scan_v_next;
    rd_slot   <= rd_slot_next;
    slot      <= slot_next;
    fam_base  <= fam_base_next;
    hits      <= hits_next;
    res       <= res_next;
  end

  always_ff @(posedge clk) begin
    if (base_we) begin
      base_mem[base_waddr] <= key;
    end
    base_rdata <= base_mem[base_raddr];
  end

  always_ff @(posedge clk) begin
    if (var_we) begin
      var_mem[var_waddr] <= var_wdata;
    end
    var_rdata <= var_mem[var_raddr];
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rule_count <= CW'(RULE_SLOTS))
    else $error("rule count beyond table size");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    rule_count != $past(rule_count) |-> rule_count == CW'($past(rule_count) + 1'b1))
    else $error("rule count moved by other than one");

  a_push_space: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_pop_ready: assert property (@(posedge clk) disable iff (rst)
    wk_pop |-> !wk_empty && state == S_IDLE)
    else $error("work popped while busy or empty");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    res_push && res.table_full |-> !res.rule_applied && res.new_tile == '0)
    else $error("table full result carries a tile");
`endif

endmodule

FILE: rtl/core/neighbor_mask_autotile_resolver_top.sv
// the engine works on one transaction at a time; scans read one table entry per cycle
// two-entry queues on the input and result sides let each side stall on its own
// reset (rst, synchronous): queues empty, rule count zero, all rules inactive, no sweep
module neighbor_mask_autotile_resolver_top #(
  parameter int RULE_SLOTS = ntr_pkg::RULE_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ntr_pkg::in_item_t  item,
  input  logic               push,
  output logic               full,
  output ntr_pkg::out_item_t result,
  output logic               empty,
  input  logic               pop
);

  ntr_pkg::work_t     wk;
  logic               wk_empty;
  logic               wk_pop;
  ntr_pkg::out_item_t res;
  logic               res_push;
  logic               res_full;
  logic [$bits(ntr_pkg::out_item_t)-1:0] result_bits;

  ntr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .push     (push),
    .full     (full),
    .wk       (wk),
    .wk_empty (wk_empty),
    .wk_pop   (wk_pop)
  );

  ntr_engine #(
    .RULE_SLOTS(RULE_SLOTS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .wk       (wk),
    .wk_empty (wk_empty),
    .wk_pop   (wk_pop),
    .res      (res),
    .res_push (res_push),
    .res_full (res_full)
  );

  ntr_fifo #(
    .WIDTH($bits(ntr_pkg::out_item_t)),
    .DEPTH(ntr_pkg::QUEUE_DEPTH)
  ) u_result_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (result_bits),
    .empty   (empty)
  );

  assign result = result_bits;

endmodule

FILE: tb/sv/tb_top.sv
// testbench for neighbor_mask_autotile_resolver_top: directed and random rule writes,
// clears and cell resolves checked against a rule-table predictor kept in the bench
// depends on ntr_pkg and the resolver rtl only
module tb_top;
  import ntr_pkg::*;

  localparam int SLOTS = RULE_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam tile_t TILE_MIN = 16'sh8000;
  localparam tile_t TILE_MAX = 16'sh7fff;

  logic clk = 1'b0;
  logic rst = 1'b1;
  in_item_t item = '0;
  logic push = 1'b0;
  logic full;
  out_item_t result;
  logic empty;
  logic pop = 1'b0;

  neighbor_mask_autotile_resolver_top #(.RULE_SLOTS(SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .item(item),
    .push(push),
    .full(full),
    .result(result),
    .empty(empty),
    .pop(pop)
  );

  always #1 clk = ~clk;

  // predicted rule table
  tile_t tbl_base [SLOTS];
  bit tbl_active [SLOTS];
  tile_t tbl_var [SLOTS][VARIANTS];
  int tbl_used = 0;

  out_item_t tile_answers[$];
  int fail_count = 0;
  int cycle_count = 0;
  int n_write = 0, n_full = 0, n_clear = 0, n_resolve = 0, n_applied = 0, n_none = 0;
  int burst_left = 0;
  bit quiet_phase = 1'b0;
  logic [9:0] pop_cycle = '0;

  tile_t tile_pool [12] = '{TILE_MIN, TILE_MAX, 16'sd0, -16'sd1, 16'sd1, 16'sd7, 16'sd42,
                            -16'sd300, 16'sd1000, 16'sd5, -16'sd2, 16'sd255};
  tile_t base_pool [10] = '{TILE_MIN, TILE_MAX, 16'sd0, -16'sd1, 16'sd3, 16'sd7, 16'sd100,
                            -16'sd50, 16'sd9, 16'sd2000};

  function automatic int find_slot(tile_t key, bit need_active);
    for (int i = 0; i < tbl_used; i++)
      if ((!need_active || tbl_active[i]) && tbl_base[i] == key) return i;
    return -1;
  endfunction

  function automatic bit in_variants(int s, tile_t key);
    for (int v = 0; v < VARIANTS; v++)
      if (tbl_var[s][v] == key) return 1'b1;
    return 1'b0;
  endfunction

  function automatic out_item_t autotile_apply(in_item_t it);
    out_item_t r;
    int s;
    logic [3:0] mask;
    tile_t nb [4];
    r = '0;
    mask = '0;
    nb = '{it.up_tile, it.right_tile, it.down_tile, it.left_tile};
    case (it.cmd)
      CMD_WRITE: begin
        n_write++;
        s = find_slot(it.base_id, 1'b0);
        if (s < 0) begin
          if (tbl_used >= SLOTS) begin
            r.table_full = 1'b1;
            n_full++;
          end else begin
            s = tbl_used;
            tbl_used++;
            tbl_base[s] = it.base_id;
            for (int v = 0; v < VARIANTS; v++) tbl_var[s][v] = '0;
          end
        end
        if (s >= 0) begin
          tbl_var[s][it.variant_index] = it.variant_value;
          tbl_active[s] = 1'b1;
        end
      end
      CMD_CLEAR: begin
        n_clear++;
        s = find_slot(it.base_id, 1'b0);
        if (s >= 0) tbl_active[s] = 1'b0;
      end
      CMD_RESOLVE: begin
        n_resolve++;
        s = find_slot(it.center_tile, 1'b1);
        if (s < 0) begin
          for (int i = 0; i < tbl_used; i++)
            if (tbl_active[i] && in_variants(i, it.center_tile)) begin
              s = i;
              break;
            end
        end
        if (s < 0) begin
          r.new_tile = it.center_tile;
        end else begin
          for (int i = 0; i < 4; i++)
            if (it.neighbor_present[i] && (nb[i] == tbl_base[s] || in_variants(s, nb[i])))
              mask[i] = 1'b1;
          r.new_tile = tbl_var[s][mask];
          r.rule_applied = 1'b1;
          n_applied++;
        end
      end
      default: n_none++;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic signed [31:0] got,
                                 logic signed [31:0] wanted);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, wanted);
    fail_count++;
  endtask

  // sender: bursts of random length separated by random gaps
  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = quiet_phase ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item <= it;
    push <= 1'b1;
    do @(posedge clk); while (full);
    tile_answers.push_back(autotile_apply(it));
  endtask

  task automatic write_rule(tile_t base, logic [3:0] idx, tile_t val);
    in_item_t it;
    it = '0;
    it.cmd = CMD_WRITE;
    it.base_id = base;
    it.variant_index = idx;
    it.variant_value = val;
    send_item(it);
  endtask

  task automatic clear_rule(tile_t base);
    in_item_t it;
    it = '0;
    it.cmd = CMD_CLEAR;
    it.base_id = base;
    send_item(it);
  endtask

  task automatic resolve_cell(tile_t center, tile_t up, tile_t right, tile_t down,
                              tile_t left, logic [3:0] present);
    in_item_t it;
    it = '0;
    it.cmd = CMD_RESOLVE;
    it.center_tile = center;
    it.up_tile = up;
    it.right_tile = right;
    it.down_tile = down;
    it.left_tile = left;
    it.neighbor_present = present;
    send_item(it);
  endtask

  function automatic tile_t pick_tile();
    if ($urandom_range(0, 1)) return tile_pool[$urandom_range(0, 11)];
    return tile_t'($urandom());
  endfunction

  function automatic tile_t pick_base();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return base_pool[$urandom_range(0, 9)];
    if (roll < 85 && tbl_used > 0) return tbl_base[$urandom_range(0, tbl_used - 1)];
    return tile_t'($urandom());
  endfunction

  function automatic tile_t family_member(int s);
    if ($urandom_range(0, 16) == 16) return tbl_base[s];
    return tbl_var[s][$urandom_range(0, VARIANTS - 1)];
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int roll;
    int s;
    it.base_id = tile_t'($urandom());
    it.variant_index = 4'($urandom_range(0, 15));
    it.variant_value = tile_t'($urandom());
    it.center_tile = tile_t'($urandom());
    it.up_tile = tile_t'($urandom());
    it.right_tile = tile_t'($urandom());
    it.down_tile = tile_t'($urandom());
    it.left_tile = tile_t'($urandom());
    it.neighbor_present = 4'($urandom_range(0, 15));
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      it.cmd = CMD_WRITE;
      it.base_id = pick_base();
      it.variant_value = pick_tile();
    end else if (roll < 45) begin
      it.cmd = CMD_CLEAR;
      it.base_id = pick_base();
    end else if (roll < 97) begin
      it.cmd = CMD_RESOLVE;
      if (tbl_used > 0 && $urandom_range(0, 3) != 0) begin
        s = $urandom_range(0, tbl_used - 1);
        it.center_tile = $urandom_range(0, 1) ? tbl_base[s] : family_member(s);
        if ($urandom_range(0, 4) != 0) it.up_tile = family_member(s);
        if ($urandom_range(0, 4) != 0) it.right_tile = family_member(s);
        if ($urandom_range(0, 4) != 0) it.down_tile = family_member(s);
        if ($urandom_range(0, 4) != 0) it.left_tile = family_member(s);
      end else begin
        it.center_tile = pick_tile();
      end
    end else begin
      it.cmd = CMD_NONE;
    end
    return it;
  endfunction

  task automatic test_empty_table();
    resolve_cell(TILE_MIN, TILE_MAX, TILE_MAX, TILE_MAX, TILE_MAX, 4'hf);
  endtask

  task automatic test_write_and_resolve();
    write_rule(TILE_MIN, 4'd0, 16'sd7);
    write_rule(TILE_MIN, 4'd15, TILE_MAX);
    write_rule(TILE_MIN, 4'd13, -16'sd1);
    resolve_cell(TILE_MIN, TILE_MIN, TILE_MIN, TILE_MIN, TILE_MIN, 4'hf);
    resolve_cell(TILE_MIN, TILE_MIN, TILE_MIN, TILE_MIN, TILE_MIN, 4'h0);
    // center found among variants, left neighbor matches a zeroed variant
    resolve_cell(16'sd7, TILE_MAX, 16'sd5, TILE_MIN, 16'sd0, 4'hf);
    resolve_cell(16'sd7, TILE_MAX, 16'sd5, TILE_MIN, 16'sd0, 4'b1010);
  endtask

  task automatic test_clear_and_reuse();
    clear_rule(TILE_MIN);
    resolve_cell(TILE_MIN, TILE_MIN, TILE_MIN, TILE_MIN, TILE_MIN, 4'hf);
    clear_rule(16'sd12345);
    // same base again: slot is reactivated and keeps its variants
    write_rule(TILE_MIN, 4'd8, 16'sd42);
    resolve_cell(16'sd7, TILE_MAX, 16'sd5, TILE_MIN, 16'sd0, 4'b1010);
  endtask

  task automatic test_unused_command();
    in_item_t it;
    it = '1;
    it.cmd = CMD_NONE;
    send_item(it);
  endtask

  task automatic test_lookup_priority();
    // base match in a later slot wins over a variant match in an earlier one
    write_rule(TILE_MAX, 4'd0, 16'sd55);
    resolve_cell(TILE_MAX, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 4'h0);
    // variant in two slots: lowest slot wins
    write_rule(TILE_MIN, 4'd3, 16'sd55);
    resolve_cell(16'sd55, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 4'h0);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      quiet_phase = (phase == 2);
      repeat (100) send_item(random_item());
    end
    quiet_phase = 1'b0;
  endtask

  task automatic test_table_full();
    while (tbl_used < SLOTS) write_rule(tile_t'($urandom()), 4'($urandom()), pick_tile());
    write_rule(tile_t'($urandom()), 4'($urandom()), pick_tile());
    write_rule(tile_t'($urandom()), 4'($urandom()), pick_tile());
    write_rule(tbl_base[SLOTS - 1], 4'd15, TILE_MIN);
    resolve_cell(tbl_base[SLOTS - 1], tbl_base[SLOTS - 1], TILE_MAX, tbl_base[SLOTS - 1],
                 TILE_MIN, 4'hf);
  endtask

  // receiver stall pattern is picked by pop_cycle[8:7] from four modes
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      pop_cycle <= '0;
    end else begin
      pop_cycle <= pop_cycle + 1'b1;
      case (pop_cycle[8:7])
        2'd0: pop <= 1'b1;
        2'd1: pop <= 1'($urandom_range(0, 1));
        2'd2: pop <= (pop_cycle[2:0] != 3'd0);
        default: pop <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (tile_answers.size() == 0) begin
        report_mismatch("result with no transaction pending", result.new_tile, 0);
      end else begin
        want = tile_answers.pop_front();
        if (result.new_tile !== want.new_tile)
          report_mismatch("new_tile", result.new_tile, want.new_tile);
        if (result.rule_applied !== want.rule_applied)
          report_mismatch("rule_applied", result.rule_applied, want.rule_applied);
        if (result.table_full !== want.table_full)
          report_mismatch("table_full", result.table_full, want.table_full);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               tile_answers.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_write_and_resolve();
    test_clear_and_reuse();
    test_unused_command();
    test_lookup_priority();
    test_random_traffic();
    test_table_full();
    push <= 1'b0;
    while (tile_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d writes (%0d refused on a full table), %0d clears, %0d no-ops",
             n_write, n_full, n_clear, n_none);
    $display("covered %0d resolves, %0d through a rule; %0d rule slots used, %0d mismatches",
             n_resolve, n_applied, tbl_used, fail_count);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: neighbor_mask_autotile_resolver_top.f
rtl/core/ntr_pkg.sv
rtl/core/ntr_fifo.sv
rtl/core/ntr_front.sv
rtl/core/ntr_engine.sv
rtl/core/neighbor_mask_autotile_resolver_top.sv
tb/sv/tb_top.sv
